/* src/afbd_pkg.sv */
//==============================================================================
// afbd_pkg
// Shared types, constants and the exp2 table of the anchor-free box decoder.
//==============================================================================
package afbd_pkg;

   // Default grid and class limits
   localparam int DEF_MAX_GRID    = 1024;
   localparam int DEF_MAX_CLASSES = 256;

   // Classes of the face head
   localparam int FACE_CLASSES = 2;

   // Control/status register port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_COUNT     = 8'd1;

   localparam logic [15:0] RST_SCORE_THRESHOLD = 16'd32768;
   localparam logic [7:0]  RST_CLASS_COUNT     = 8'd80;

   // Datapath widths
   localparam int CTR_SUM_W = 24;   // offset + cell, Q.12
   localparam int CTR_W     = 33;   // centre, Q.12 pixels
   localparam int HALF_W    = 32;   // half size, Q.12 pixels
   localparam int CORNER_W  = 36;   // corner before rounding
   localparam int COORD_W   = 24;   // Q20.4 output

   localparam logic signed [27:0] COORD_MAX = 28'sd8388607;
   localparam logic signed [27:0] COORD_MIN = -28'sd8388608;

   // log2(e) in Q.16
   localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;

   // round(2^(i/16) * 65536), i = 0..16
   localparam logic [17:0] POW2_FRAC [17] = '{
      18'd65536,  18'd68438,  18'd71468,  18'd74632,  18'd77936,
      18'd81386,  18'd84990,  18'd88752,  18'd92682,  18'd96785,
      18'd101070, 18'd105545, 18'd110218, 18'd115098, 18'd120194,
      18'd125515, 18'd131072
   };

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [15:0] score_threshold;
      logic [7:0]  class_count;
   } cfg_type;

endpackage

/* src/afbd_csr.sv */
//==============================================================================
// afbd_csr
// Configuration registers: score threshold and class count.
//==============================================================================
module afbd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [afbd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [afbd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output afbd_pkg::cfg_type              cfg
);
   import afbd_pkg::*;

   logic [15:0] threshold_ff;
   logic [7:0]  class_count_ff;
   logic        csr_write;

   assign csr_ready = ~reset;
   assign csr_write = csr_valid & csr_ready;

   // Register write decode; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= RST_SCORE_THRESHOLD;
         class_count_ff <= RST_CLASS_COUNT;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SCORE_THRESHOLD: threshold_ff   <= csr_wdata[15:0];
            CSR_CLASS_COUNT:     class_count_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg.score_threshold = threshold_ff;
   assign cfg.class_count     = class_count_ff;

endmodule

/* src/afbd_half_size.sv */
//==============================================================================
// afbd_half_size
// Four-stage pipeline: half of exp(log size) * stride in Q.12 pixels.
//==============================================================================
module afbd_half_size (
   input  logic                              clock,
   input  logic signed [15:0]                log_size,
   input  logic [7:0]                        stride,
   output logic [afbd_pkg::HALF_W-1:0]       half_size
);
   import afbd_pkg::*;

   // Stage 1: log size times log2(e)
   logic signed [33:0] prod_in, prod_ff;
   logic [7:0]         stride1_ff;

   // Stage 2: split exponent / fraction, table and interpolation product
   logic signed [21:0] y;
   logic signed [5:0]  exp_in, exp2_ff;
   logic [4:0]         idx_lo, idx_hi;
   logic [11:0]        frac_lo;
   logic [12:0]        diff;
   logic [17:0]        base_ff;
   logic [24:0]        interp_in, interp_ff;
   logic [7:0]         stride2_ff;

   // Stage 3: mantissa times stride
   logic [17:0]        mant;
   logic [25:0]        p_in, p_ff;
   logic signed [5:0]  exp3_ff;

   // Stage 4: scale by 2^(e-5)
   logic signed [5:0]  shamt;
   logic [4:0]         rshamt;
   logic [HALF_W-1:0]  half_in, half_ff;

   assign prod_in = 34'(log_size) * LOG2E_Q16;

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      stride1_ff <= stride;
   end

   // floor(prod / 4096), then e = floor(y / 65536), f = y mod 65536
   assign y       = prod_ff[33:12];
   assign exp_in  = y[21:16];
   assign idx_lo  = {1'b0, y[15:12]};
   assign idx_hi  = idx_lo + 5'd1;
   assign frac_lo = y[11:0];
   assign diff    = 13'(POW2_FRAC[idx_hi] - POW2_FRAC[idx_lo]);
   assign interp_in = 25'(diff) * 25'(frac_lo);

   always_ff @(posedge clock) begin
      base_ff    <= POW2_FRAC[idx_lo];
      interp_ff  <= interp_in;
      exp2_ff    <= exp_in;
      stride2_ff <= stride1_ff;
   end

   assign mant = base_ff + 18'(interp_ff[24:12]);
   assign p_in = 26'(mant) * 26'(stride2_ff);

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      exp3_ff <= exp2_ff;
   end

   // Left shift up to 6, right shift up to 17
   assign shamt  = exp3_ff - 6'sd5;
   assign rshamt = 5'(-shamt);

   always_comb begin
      if (shamt >= 6'sd0) begin
         half_in = HALF_W'(p_ff) << shamt[2:0];
      end else begin
         half_in = HALF_W'(p_ff) >> rshamt;
      end
   end

   always_ff @(posedge clock) begin
      half_ff <= half_in;
   end

   assign half_size = half_ff;

endmodule

/* src/anchor_free_box_decode.sv */
//==============================================================================
// anchor_free_box_decode
// Decodes one grid cell / class score pair into a thresholded pixel box.
//==============================================================================
// Usage:
//   A request (one cell paired with one class score) is taken at a rising
//   edge with start high and busy low. busy is high only while reset is
//   applied, so a new request may be issued every cycle.
//   A request that passes the range, class and score checks produces one
//   box on the rsp_ ports, marked by rsp_valid for exactly one cycle; a
//   request that fails produces nothing. Results keep request order.
//   A request passes through five register stages: score/sum,
//   threshold/centre and exp2 table, mantissa times stride, exponent
//   shift, corner round and saturate. Throughput is one request per
//   cycle outside reset. The receiver cannot stall; results are never
//   held back. Registers are written on the csr_ channel (index 0 score
//   threshold, index 1 class count); the user must write them only while
//   no request is in flight, which the block itself does not enforce.
//   csr_ready is high outside reset. Reset (synchronous) clears the
//   pipeline and loads threshold 32768 and class count 80.
//==============================================================================
module anchor_free_box_decode #(
   parameter int MAX_GRID    = afbd_pkg::DEF_MAX_GRID,
   parameter int MAX_CLASSES = afbd_pkg::DEF_MAX_CLASSES
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_mode,
   input  logic [15:0]                     req_objectness,
   input  logic [15:0]                     req_class_score,
   input  logic [7:0]                      req_class_index,
   input  logic signed [15:0]              req_reg_dx,
   input  logic signed [15:0]              req_reg_dy,
   input  logic signed [15:0]              req_reg_log_w,
   input  logic signed [15:0]              req_reg_log_h,
   input  logic [9:0]                      req_cell_col,
   input  logic [9:0]                      req_cell_row,
   input  logic [7:0]                      req_stride,
   // result channel
   output logic                            rsp_valid,
   output logic signed [23:0]              rsp_box_x_min,
   output logic signed [23:0]              rsp_box_y_min,
   output logic signed [23:0]              rsp_box_x_max,
   output logic signed [23:0]              rsp_box_y_max,
   output logic [8:0]                      rsp_label,
   output logic [15:0]                     rsp_score,
   // configuration channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [afbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [afbd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import afbd_pkg::*;

   cfg_type cfg;
   logic    accept;

   // Round Q.12 half up to Q.4 and saturate to 24 bits
   function automatic logic signed [COORD_W-1:0] round_sat(
      input logic signed [CORNER_W-1:0] v
   );
      logic signed [CORNER_W-1:0] t;
      logic signed [27:0]         q;
      t = v + CORNER_W'(128);
      q = 28'(t >>> 8);
      if (q > COORD_MAX) begin
         q = COORD_MAX;
      end else if (q < COORD_MIN) begin
         q = COORD_MIN;
      end
      return COORD_W'(q);
   endfunction

   afbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign busy   = reset;
   assign accept = start & ~busy;

   // ---------------------------------------------------------------- stage 1
   logic                        grid_ok, class_ok, pass_in;
   logic signed [CTR_SUM_W-1:0] sumx_in, sumy_in;
   logic [8:0]                  label_in;
   logic                        v1_ff, pass1_ff;
   logic [31:0]                 sprod1_ff;
   logic signed [CTR_SUM_W-1:0] sumx1_ff, sumy1_ff;
   logic [7:0]                  stride1_ff;
   logic [8:0]                  label1_ff;

   assign grid_ok  = (32'(req_cell_col) < MAX_GRID) && (32'(req_cell_row) < MAX_GRID);
   assign class_ok = (32'(req_class_index) < MAX_CLASSES) &&
                     (req_mode ? (32'(req_class_index) < FACE_CLASSES)
                               : (req_class_index < cfg.class_count));
   assign pass_in  = grid_ok && class_ok && (req_objectness >= cfg.score_threshold);

   assign sumx_in  = CTR_SUM_W'(req_reg_dx) + $signed({2'b00, req_cell_col, 12'h000});
   assign sumy_in  = CTR_SUM_W'(req_reg_dy) + $signed({2'b00, req_cell_row, 12'h000});
   assign label_in = 9'(req_class_index) + (req_mode ? 9'(cfg.class_count) : 9'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      pass1_ff   <= pass_in;
      sprod1_ff  <= 32'(req_objectness) * 32'(req_class_score);
      sumx1_ff   <= sumx_in;
      sumy1_ff   <= sumy_in;
      stride1_ff <= req_stride;
      label1_ff  <= label_in;
   end

   // ---------------------------------------------------------------- stage 2
   logic                    keep2_in, keep2_ff;
   logic [15:0]             score2_ff;
   logic signed [CTR_W-1:0] stride_s;
   logic signed [CTR_W-1:0] cx2_ff, cy2_ff;
   logic [8:0]              label2_ff;

   assign keep2_in = v1_ff && pass1_ff && (sprod1_ff[31:16] >= cfg.score_threshold);
   assign stride_s = $signed({25'd0, stride1_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         keep2_ff <= 1'b0;
      end else begin
         keep2_ff <= keep2_in;
      end
   end

   always_ff @(posedge clock) begin
      score2_ff <= sprod1_ff[31:16];
      cx2_ff    <= CTR_W'(sumx1_ff) * stride_s;
      cy2_ff    <= CTR_W'(sumy1_ff) * stride_s;
      label2_ff <= label1_ff;
   end

   // ------------------------------------------------------- stages 3 and 4
   logic                    keep3_ff, keep4_ff;
   logic [15:0]             score3_ff, score4_ff;
   logic signed [CTR_W-1:0] cx3_ff, cy3_ff, cx4_ff, cy4_ff;
   logic [8:0]              label3_ff, label4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep3_ff <= 1'b0;
         keep4_ff <= 1'b0;
      end else begin
         keep3_ff <= keep2_ff;
         keep4_ff <= keep3_ff;
      end
   end

   always_ff @(posedge clock) begin
      score3_ff <= score2_ff;
      score4_ff <= score3_ff;
      cx3_ff    <= cx2_ff;
      cx4_ff    <= cx3_ff;
      cy3_ff    <= cy2_ff;
      cy4_ff    <= cy3_ff;
      label3_ff <= label2_ff;
      label4_ff <= label3_ff;
   end

   // Half sizes, aligned with stage 4
   logic [HALF_W-1:0] half_w, half_h;

   afbd_half_size u_half_w (
      .clock     (clock),
      .log_size  (req_reg_log_w),
      .stride    (req_stride),
      .half_size (half_w)
   );

   afbd_half_size u_half_h (
      .clock     (clock),
      .log_size  (req_reg_log_h),
      .stride    (req_stride),
      .half_size (half_h)
   );

   // ---------------------------------------------------------------- stage 5
   logic signed [CORNER_W-1:0] cx_e, cy_e, hw_e, hh_e;
   logic                       rsp_valid_ff;
   logic signed [COORD_W-1:0]  x_min_ff, y_min_ff, x_max_ff, y_max_ff;
   logic [8:0]                 label_ff;
   logic [15:0]                score_ff;

   assign cx_e = CORNER_W'(cx4_ff);
   assign cy_e = CORNER_W'(cy4_ff);
   assign hw_e = $signed({4'h0, half_w});
   assign hh_e = $signed({4'h0, half_h});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= keep4_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_min_ff <= round_sat(cx_e - hw_e);
      y_min_ff <= round_sat(cy_e - hh_e);
      x_max_ff <= round_sat(cx_e + hw_e);
      y_max_ff <= round_sat(cy_e + hh_e);
      label_ff <= label4_ff;
      score_ff <= score4_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_box_x_min = x_min_ff;
   assign rsp_box_y_min = y_min_ff;
   assign rsp_box_x_max = x_max_ff;
   assign rsp_box_y_max = y_max_ff;
   assign rsp_label     = label_ff;
   assign rsp_score     = score_ff;

   // ------------------------------------------------------------- checks
   // A result always comes from an accepted request
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result without matching request");

   // Nothing leaves the pipeline right after a reset edge
   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result right after reset");

   // Corners are ordered since half size is never negative
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_box_x_min <= rsp_box_x_max) && (rsp_box_y_min <= rsp_box_y_max))
      else $error("box corners out of order");

   // A zero stride collapses the box to the origin
   a_zero_stride: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(req_stride, 5) == 8'd0) |->
         (rsp_box_x_min == 24'sd0) && (rsp_box_x_max == 24'sd0) &&
         (rsp_box_y_min == 24'sd0) && (rsp_box_y_max == 24'sd0))
      else $error("zero stride gave a non-empty box");

endmodule
